@@ src/codepage_to_utf16_decoder_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the code page to UTF-16 decoder
// Simulation-only property checks; empty when synthesized.
// ----------------------------------------------------------------------------
`ifndef CODEPAGE_TO_UTF16_DECODER_ASSERT_SVH
`define CODEPAGE_TO_UTF16_DECODER_ASSERT_SVH
`ifndef SYNTHESIS
`define CTD_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("ctd assertion failed");
`define CTD_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("ctd assertion failed");
`else
`define CTD_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define CTD_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

@@ src/ctd_pkg.sv @@
// ----------------------------------------------------------------------------
// ctd_pkg
// Types, codes and the CP1252 high-range table of the decoder.
// ----------------------------------------------------------------------------
package ctd_pkg;

	localparam int BYTE_W   = 8;
	localparam int UNIT_W   = 16;
	localparam int STAT_W   = 2;
	localparam int MODE_W   = 2;
	localparam int POINT_W  = 21;
	localparam int PEND_W   = 2;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 2;
	localparam int QUEUE_DEPTH = 4;

	localparam logic [MODE_W-1:0] MODE_CP1252 = 2'd0;
	localparam logic [MODE_W-1:0] MODE_UTF8   = 2'd1;
	localparam logic [MODE_W-1:0] MODE_LATIN1 = 2'd2;

	localparam logic [STAT_W-1:0] STAT_OK        = 2'd0;
	localparam logic [STAT_W-1:0] STAT_MALFORMED = 2'd1;
	localparam logic [STAT_W-1:0] STAT_BEYOND    = 2'd2;

	localparam logic [CFG_IDX_W-1:0] REG_CODEPAGE_MODE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_APPEND_TERM   = 2'd1;

	typedef struct packed {
		logic [UNIT_W-1:0] unit;
		logic [STAT_W-1:0] status;
		logic              last;
		logic              term;
	} ctd_op_t;

	function automatic logic [UNIT_W-1:0] hi_range_unit(input logic [4:0] idx);
		logic [UNIT_W-1:0] u;
		case (idx)
			5'd0:  u = 16'h20AC;
			5'd1:  u = 16'h0081;
			5'd2:  u = 16'h201A;
			5'd3:  u = 16'h0192;
			5'd4:  u = 16'h201E;
			5'd5:  u = 16'h2026;
			5'd6:  u = 16'h2020;
			5'd7:  u = 16'h2021;
			5'd8:  u = 16'h02C6;
			5'd9:  u = 16'h2030;
			5'd10: u = 16'h0160;
			5'd11: u = 16'h2039;
			5'd12: u = 16'h0152;
			5'd13: u = 16'h008D;
			5'd14: u = 16'h017D;
			5'd15: u = 16'h008F;
			5'd16: u = 16'h0090;
			5'd17: u = 16'h2018;
			5'd18: u = 16'h2019;
			5'd19: u = 16'h201C;
			5'd20: u = 16'h201D;
			5'd21: u = 16'h2022;
			5'd22: u = 16'h2013;
			5'd23: u = 16'h2014;
			5'd24: u = 16'h02DC;
			5'd25: u = 16'h2122;
			5'd26: u = 16'h0161;
			5'd27: u = 16'h203A;
			5'd28: u = 16'h0153;
			5'd29: u = 16'h009D;
			5'd30: u = 16'h017E;
			5'd31: u = 16'h0178;
			default: u = 16'h0000;
		endcase
		return u;
	endfunction

endpackage

@@ src/ctd_if.sv @@
// ----------------------------------------------------------------------------
// ctd interfaces
// Byte input, code unit output and configuration write channels.
// ----------------------------------------------------------------------------
interface ctd_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;
	logic       final_byte;
	modport source (output valid, output in_byte, output final_byte, input ready);
	modport sink (input valid, input in_byte, input final_byte, output ready);
endinterface

interface ctd_unit_if;
	logic        valid;
	logic        ready;
	logic [15:0] code_unit;
	logic [1:0]  status;
	logic        end_of_string;
	logic [15:0] unit_count;
	modport source (output valid, output code_unit, output status, output end_of_string,
		output unit_count, input ready);
	modport sink (input valid, input code_unit, input status, input end_of_string,
		input unit_count, output ready);
endinterface

interface ctd_cfg_if;
	logic       valid;
	logic       ready;
	logic [1:0] index;
	logic [1:0] data;
	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

@@ src/codepage_to_utf16_decoder.sv @@
// ----------------------------------------------------------------------------
// codepage_to_utf16_decoder
// CP1252, UTF-8 or Latin-1 byte stream to UTF-16 code units.
// ----------------------------------------------------------------------------
//  channel | dir | beat
//  bytes   | in  | in_byte, final_byte
//  units   | out | code_unit, status, end_of_string, unit_count
//  cfg     | in  | index, data (0 codepage_mode, 1 append_terminator)
//
//  One byte per cycle is accepted while the op queue has room; a final byte
//  with a terminator yields two beats, a code unit and then a terminator.
//  A byte's result beat passes through the queue and then the output register.
//  arst_n clears decode state, queue, unit count and config registers to defaults.
//  A stalled units channel fills the four-entry queue before bytes stall.
// ----------------------------------------------------------------------------
module codepage_to_utf16_decoder #(
	parameter int COUNT_BITS = 16
) (
	input  logic       clk,
	input  logic       arst_n,
	ctd_byte_if.sink   bytes,
	ctd_unit_if.source units,
	ctd_cfg_if.sink    cfg
);
	import ctd_pkg::*;

	logic [MODE_W-1:0] mode_q;
	logic              term_en_q;
	logic              q_full, push, pop, head_valid;
	ctd_op_t           push_op, head_op;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q    <= MODE_CP1252;
			term_en_q <= 1'b1;
		end else if (cfg.valid) begin
			if (cfg.index == REG_CODEPAGE_MODE) begin
				mode_q <= cfg.data[MODE_W-1:0];
			end else if (cfg.index == REG_APPEND_TERM) begin
				term_en_q <= cfg.data[0];
			end
		end
	end

	ctd_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.bytes   (bytes),
		.mode    (mode_q),
		.term_en (term_en_q),
		.q_full  (q_full),
		.push    (push),
		.op      (push_op)
	);

	ctd_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_op    (push_op),
		.pop        (pop),
		.full       (q_full),
		.head_valid (head_valid),
		.head_op    (head_op)
	);

	ctd_back #(
		.COUNT_BITS (COUNT_BITS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head_op    (head_op),
		.pop        (pop),
		.units      (units)
	);

endmodule

@@ src/ctd_front.sv @@
// ----------------------------------------------------------------------------
// ctd_front
// Accepts bytes, tracks UTF-8 sequences and error dropping, issues unit ops.
// ----------------------------------------------------------------------------
module ctd_front (
	input  logic                        clk,
	input  logic                        arst_n,
	ctd_byte_if.sink                    bytes,
	input  logic [ctd_pkg::MODE_W-1:0]  mode,
	input  logic                        term_en,
	input  logic                        q_full,
	output logic                        push,
	output ctd_pkg::ctd_op_t            op
);
	import ctd_pkg::*;

	logic [POINT_W-1:0] pp_q, pp_nxt, pp_shift;
	logic [PEND_W-1:0]  pend_q, pend_nxt, pend_dec;
	logic               drop_q, drop_nxt;
	logic               accept, want;
	logic [7:0]         b;
	logic               last;

	assign bytes.ready = !q_full;
	assign accept      = bytes.valid && bytes.ready;
	assign b           = bytes.in_byte;
	assign last        = bytes.final_byte;
	assign pp_shift    = {pp_q[POINT_W-7:0], b[5:0]};
	assign pend_dec    = pend_q - 1'b1;
	assign push        = accept && want;

	always_comb begin
		want     = 1'b0;
		op       = '0;
		pp_nxt   = pp_q;
		pend_nxt = pend_q;
		drop_nxt = drop_q;
		if (drop_q) begin
			if (last) begin
				drop_nxt = 1'b0;
			end
		end else if (mode != MODE_UTF8) begin
			want     = 1'b1;
			op.unit  = {8'h00, b};
			if (mode == MODE_CP1252 && b[7:5] == 3'b100) begin
				op.unit = hi_range_unit(b[4:0]);
			end
			op.status = STAT_OK;
			op.last   = last;
			op.term   = last && term_en;
			pp_nxt    = '0;
			pend_nxt  = '0;
		end else if (pend_q == '0) begin
			if (!b[7]) begin
				want      = 1'b1;
				op.unit   = {8'h00, b};
				op.status = STAT_OK;
				op.last   = last;
				op.term   = last && term_en;
			end else if (b[7:5] == 3'b110 || b[7:4] == 4'b1110 || b[7:3] == 5'b11110) begin
				if (b[7:5] == 3'b110) begin
					pp_nxt   = POINT_W'(b[4:0]);
					pend_nxt = 2'd1;
				end else if (b[7:4] == 4'b1110) begin
					pp_nxt   = POINT_W'(b[3:0]);
					pend_nxt = 2'd2;
				end else begin
					pp_nxt   = POINT_W'(b[2:0]);
					pend_nxt = 2'd3;
				end
				if (last) begin
					want      = 1'b1;
					op.status = STAT_MALFORMED;
					op.last   = 1'b1;
					pp_nxt    = '0;
					pend_nxt  = '0;
				end
			end else begin
				want      = 1'b1;
				op.status = STAT_MALFORMED;
				op.last   = 1'b1;
				drop_nxt  = !last;
			end
		end else begin
			pp_nxt   = pp_shift;
			pend_nxt = pend_dec;
			if (pend_dec != '0) begin
				if (last) begin
					want      = 1'b1;
					op.status = STAT_MALFORMED;
					op.last   = 1'b1;
					pp_nxt    = '0;
					pend_nxt  = '0;
				end
			end else if (|pp_shift[POINT_W-1:UNIT_W]) begin
				want      = 1'b1;
				op.status = STAT_BEYOND;
				op.last   = 1'b1;
				drop_nxt  = !last;
				pp_nxt    = '0;
			end else begin
				want      = 1'b1;
				op.unit   = pp_shift[UNIT_W-1:0];
				op.status = STAT_OK;
				op.last   = last;
				op.term   = last && term_en;
				pp_nxt    = '0;
			end
		end
		if (last) begin
			pp_nxt   = '0;
			pend_nxt = '0;
			drop_nxt = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pp_q   <= '0;
			pend_q <= '0;
			drop_q <= 1'b0;
		end else if (accept) begin
			pp_q   <= pp_nxt;
			pend_q <= pend_nxt;
			drop_q <= drop_nxt;
		end
	end

endmodule

@@ src/ctd_queue.sv @@
// ----------------------------------------------------------------------------
// ctd_queue
// Short FIFO of unit ops between the front and back ends.
// ----------------------------------------------------------------------------
`include "codepage_to_utf16_decoder_assert.svh"

module ctd_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  ctd_pkg::ctd_op_t push_op,
	input  logic             pop,
	output logic             full,
	output logic             head_valid,
	output ctd_pkg::ctd_op_t head_op
);
	import ctd_pkg::*;

	localparam int PTR_W = $clog2(QUEUE_DEPTH);
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	ctd_op_t            mem_q [QUEUE_DEPTH];
	logic [PTR_W-1:0]   wr_q, rd_q;
	logic [CNT_W-1:0]   cnt_q;
	logic               do_pop;

	assign full       = cnt_q == CNT_W'(QUEUE_DEPTH);
	assign head_valid = cnt_q != '0;
	assign head_op    = mem_q[rd_q];
	assign do_pop     = pop && head_valid;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_op;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (do_pop) begin
				rd_q <= rd_q + 1'b1;
			end
			if (push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (!push && do_pop) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	`CTD_ASSERT_IMP(a_no_push_full, clk, arst_n, push, !full || do_pop)
	`CTD_ASSERT_IMP(a_cnt_bound, clk, arst_n, 1'b1, cnt_q <= CNT_W'(QUEUE_DEPTH))
	`CTD_ASSERT_NXT(a_pop_drains, clk, arst_n, do_pop && !push && cnt_q == CNT_W'(1),
		!head_valid)

endmodule

@@ src/ctd_back.sv @@
// ----------------------------------------------------------------------------
// ctd_back
// Turns unit ops into result beats, adds terminators, keeps the unit count.
// ----------------------------------------------------------------------------
`include "codepage_to_utf16_decoder_assert.svh"

module ctd_back #(
	parameter int COUNT_BITS = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             head_valid,
	input  ctd_pkg::ctd_op_t head_op,
	output logic             pop,
	ctd_unit_if.source       units
);
	import ctd_pkg::*;

	logic [COUNT_BITS-1:0] cnt_q, cnt_inc, beat_cnt;
	logic                  phase_q;
	logic                  load;
	logic                  beat_ok, beat_end;
	logic [UNIT_W-1:0]     beat_unit;
	logic [STAT_W-1:0]     beat_stat;
	logic                  out_valid_q;
	logic [UNIT_W-1:0]     unit_q;
	logic [STAT_W-1:0]     stat_q;
	logic                  end_q;
	logic [15:0]           count_q;

	assign load    = head_valid && (!out_valid_q || units.ready);
	assign cnt_inc = (cnt_q == '1) ? cnt_q : cnt_q + 1'b1;

	always_comb begin
		if (phase_q) begin
			beat_unit = '0;
			beat_stat = STAT_OK;
			beat_end  = 1'b1;
			pop       = load;
		end else begin
			beat_unit = head_op.unit;
			beat_stat = head_op.status;
			beat_end  = (head_op.status != STAT_OK) || (head_op.last && !head_op.term);
			pop       = load && !head_op.term;
		end
		beat_ok  = beat_stat == STAT_OK;
		beat_cnt = beat_ok ? cnt_inc : cnt_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			phase_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				cnt_q       <= beat_end ? '0 : beat_cnt;
				phase_q     <= !phase_q && head_op.term;
				out_valid_q <= 1'b1;
			end else if (units.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			unit_q  <= beat_unit;
			stat_q  <= beat_stat;
			end_q   <= beat_end;
			count_q <= 16'(beat_cnt);
		end
	end

	assign units.valid         = out_valid_q;
	assign units.code_unit     = unit_q;
	assign units.status        = stat_q;
	assign units.end_of_string = end_q;
	assign units.unit_count    = count_q;

	`CTD_ASSERT_IMP(a_term_has_head, clk, arst_n, phase_q, head_valid && head_op.term)
	`CTD_ASSERT_IMP(a_err_beat, clk, arst_n, out_valid_q && stat_q != STAT_OK,
		unit_q == '0 && end_q)
	`CTD_ASSERT_NXT(a_end_clears, clk, arst_n, load && beat_end, cnt_q == '0 && !phase_q)

endmodule
